### rtl/dswer_pkg.sv
// Shared constants and controller/datapath handshake types for the event rate counter.
`default_nettype none

package dswer_pkg;

	// Fixed field widths on the ports
	localparam int TIME_W = 32;
	localparam int WIN_W  = 32;
	localparam int RATE_W = 7;

	// Defaults for the top level parameters
	localparam int DEF_FIFO_DEPTH = 64;
	localparam int DEF_TIME_BITS  = 32;

	// Window register value after reset
	localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000;

	// Rate and peak outputs saturate here
	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;  // take the input beat
		logic push;     // write new stamps into the FIFOs
		logic read;     // fetch the head stamp of each FIFO
		logic check;    // compare head ages, pop expired stamps
		logic finish;   // update peaks and load the result register
	} cmd_t;

	// Status from the datapath back to the controller
	typedef struct packed {
		logic pop_any;  // at least one channel popped this cycle
		logic out_free; // result register can take a new beat
	} sts_t;

endpackage

`default_nettype wire

### rtl/dswer_if.sv
// Valid/ready channel interfaces: sample input, result output, window register write.
`default_nettype none

interface dswer_sample_if;
	import dswer_pkg::*;
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] time_now;
	logic              left_pressed;
	logic              right_pressed;

	modport source (output valid, output time_now, output left_pressed,
		output right_pressed, input ready);
	modport sink (input valid, input time_now, input left_pressed,
		input right_pressed, output ready);
endinterface

interface dswer_result_if;
	import dswer_pkg::*;
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] left_rate;
	logic [RATE_W-1:0] right_rate;
	logic [RATE_W-1:0] left_peak;
	logic [RATE_W-1:0] right_peak;
	logic              overflow;

	modport source (output valid, output left_rate, output right_rate,
		output left_peak, output right_peak, output overflow, input ready);
	modport sink (input valid, input left_rate, input right_rate,
		input left_peak, input right_peak, input overflow, output ready);
endinterface

interface dswer_cfg_if;
	import dswer_pkg::*;
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] window_ticks;

	modport source (output valid, output window_ticks, input ready);
	modport sink (input valid, input window_ticks, output ready);
endinterface

`default_nettype wire

### rtl/dual_sliding_window_event_rate.sv
// Top level of the dual sliding-window button event rate counter.
`default_nettype none

// Each sample beat carries a timestamp and two button levels; a rising edge on a
// channel pushes the timestamp into that channel's stamp FIFO, then stamps older
// than window_ticks are popped and one result beat reports both counts, their
// peaks since reset and a dropped-press flag. Each sample steps through the PUSH,
// READ, CHECK and FINISH states before the block is back in IDLE, and each
// expiry round repeats READ and CHECK. Both channels pop in the same round, so
// the round count is the larger of the two pop counts. A round needs both
// states because each stamp memory has a single registered read port.
// A finished result waits in an output register, so the next sample is taken
// while it is pending; it only stalls at the end if the previous result is
// still untaken. The window register may be written at any time the block is
// idle; its port is always ready.
module dual_sliding_window_event_rate #(
	parameter int FIFO_DEPTH = dswer_pkg::DEF_FIFO_DEPTH,
	parameter int TIME_BITS  = dswer_pkg::DEF_TIME_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dswer_sample_if.sink     sample,
	dswer_result_if.source   result,
	dswer_cfg_if.sink        cfg
);
	import dswer_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	dswer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dswer_dp #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.time_now    (sample.time_now),
		.left_level  (sample.left_pressed),
		.right_level (sample.right_pressed),
		.win_we      (cfg.valid),
		.win_data    (cfg.window_ticks),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.left_rate   (result.left_rate),
		.right_rate  (result.right_rate),
		.left_peak   (result.left_peak),
		.right_peak  (result.right_peak),
		.overflow    (result.overflow)
	);

endmodule

`default_nettype wire

### rtl/dswer_ctrl.sv
// Sequencing state machine: capture, push, read/check expiry loop, result load.
`default_nettype none

module dswer_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  dswer_pkg::sts_t    sts,
	output dswer_pkg::cmd_t    cmd
);
	import dswer_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PUSH   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_CHECK  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nx;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_PUSH;
			end
			ST_PUSH:  state_nx = ST_READ;
			ST_READ:  state_nx = ST_CHECK;
			ST_CHECK: begin
				// another pop means a new head stamp must be fetched
				state_nx = sts.pop_any ? ST_READ : ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Command decode
	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.push    = (state_q == ST_PUSH);
	assign cmd.read    = (state_q == ST_READ);
	assign cmd.check   = (state_q == ST_CHECK);
	assign cmd.finish  = (state_q == ST_FINISH) && sts.out_free;

endmodule

`default_nettype wire

### rtl/dswer_chan.sv
// One button channel: stamp FIFO memory, head/fill pointers, edge detect, peak.
`default_nettype none

module dswer_chan #(
	parameter int FIFO_DEPTH = dswer_pkg::DEF_FIFO_DEPTH,
	parameter int TIME_BITS  = dswer_pkg::DEF_TIME_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  dswer_pkg::cmd_t                   cmd,
	input  wire logic                         level,
	input  wire logic [TIME_BITS-1:0]         now,
	input  wire logic [dswer_pkg::WIN_W-1:0]  window,
	output logic                              pop,
	output logic                              drop,
	output logic [dswer_pkg::RATE_W-1:0]      rate,
	output logic [dswer_pkg::RATE_W-1:0]      peak
);
	import dswer_pkg::*;

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int SW = (FW > RATE_W) ? FW : RATE_W;
	localparam int CW = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
	localparam logic [FW-1:0] FULL    = FW'(FIFO_DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(FIFO_DEPTH - 1);
	localparam logic [FW:0]   DEPTH_X = (FW + 1)'(FIFO_DEPTH);

	logic [TIME_BITS-1:0] mem [FIFO_DEPTH];
	logic [TIME_BITS-1:0] rd_q;
	logic [AW-1:0]        head_q;
	logic [FW-1:0]        fill_q;
	logic [FW-1:0]        peak_q;
	logic                 prev_q;
	logic                 push_q;
	logic                 drop_q;

	logic                 rise;
	logic [FW:0]          tail_sum;
	logic [FW:0]          tail_wrap;
	logic [AW-1:0]        tail;
	logic [TIME_BITS-1:0] age;
	logic [FW-1:0]        peak_nx;
	logic [SW-1:0]        fill_x;
	logic [SW-1:0]        peak_x;

	// Edge detect on the sampled level
	assign rise = level & ~prev_q;

	// Tail slot = head + fill, wrapped at the FIFO depth
	assign tail_sum  = (FW + 1)'(head_q) + (FW + 1)'(fill_q);
	assign tail_wrap = (tail_sum >= DEPTH_X) ? (tail_sum - DEPTH_X) : tail_sum;
	assign tail      = tail_wrap[AW-1:0];

	// Head stamp expires when its modular age exceeds the window
	assign age = now - rd_q;
	assign pop = cmd.check && (fill_q != '0) && (CW'(age) > CW'(window));

	// Stamp memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push && push_q) mem[tail] <= now;
		if (cmd.read) rd_q <= mem[head_q];
	end

	// Pointers, fill count, edge and peak state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			peak_q <= '0;
			prev_q <= 1'b0;
			push_q <= 1'b0;
			drop_q <= 1'b0;
		end else if (cmd.capture) begin
			prev_q <= level;
			push_q <= rise && (fill_q != FULL);
			drop_q <= rise && (fill_q == FULL);
		end else if (cmd.push) begin
			if (push_q) fill_q <= fill_q + 1'b1;
		end else if (pop) begin
			head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
			fill_q <= fill_q - 1'b1;
		end else if (cmd.finish) begin
			peak_q <= peak_nx;
		end
	end

	assign peak_nx = (fill_q > peak_q) ? fill_q : peak_q;
	assign drop    = drop_q;

	// Saturating 7-bit views
	assign fill_x = SW'(fill_q);
	assign peak_x = SW'(peak_nx);
	assign rate   = (fill_x > SW'(RATE_MAX)) ? RATE_MAX : fill_x[RATE_W-1:0];
	assign peak   = (peak_x > SW'(RATE_MAX)) ? RATE_MAX : peak_x[RATE_W-1:0];

endmodule

`default_nettype wire

### rtl/dswer_dp.sv
// Datapath: window register, sample capture, both channels, result register.
`default_nettype none

module dswer_dp #(
	parameter int FIFO_DEPTH = dswer_pkg::DEF_FIFO_DEPTH,
	parameter int TIME_BITS  = dswer_pkg::DEF_TIME_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  dswer_pkg::cmd_t                    cmd,
	output dswer_pkg::sts_t                    sts,
	input  wire logic [dswer_pkg::TIME_W-1:0]  time_now,
	input  wire logic                          left_level,
	input  wire logic                          right_level,
	input  wire logic                          win_we,
	input  wire logic [dswer_pkg::WIN_W-1:0]   win_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [dswer_pkg::RATE_W-1:0]       left_rate,
	output logic [dswer_pkg::RATE_W-1:0]       right_rate,
	output logic [dswer_pkg::RATE_W-1:0]       left_peak,
	output logic [dswer_pkg::RATE_W-1:0]       right_peak,
	output logic                               overflow
);
	import dswer_pkg::*;

	logic [WIN_W-1:0]     win_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 valid_q;
	logic [RATE_W-1:0]    l_rate_q;
	logic [RATE_W-1:0]    r_rate_q;
	logic [RATE_W-1:0]    l_peak_q;
	logic [RATE_W-1:0]    r_peak_q;
	logic                 ovf_q;

	logic                 l_pop;
	logic                 r_pop;
	logic                 l_drop;
	logic                 r_drop;
	logic [RATE_W-1:0]    l_rate;
	logic [RATE_W-1:0]    r_rate;
	logic [RATE_W-1:0]    l_peak;
	logic [RATE_W-1:0]    r_peak;

	// Window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
		end else if (win_we) begin
			win_q <= win_data;
		end
	end

	// Timestamp of the current sample, taken modulo 2^TIME_BITS
	always_ff @(posedge clk) begin
		if (cmd.capture) now_q <= TIME_BITS'(time_now);
	end

	dswer_chan #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.TIME_BITS  (TIME_BITS)
	) u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.level  (left_level),
		.now    (now_q),
		.window (win_q),
		.pop    (l_pop),
		.drop   (l_drop),
		.rate   (l_rate),
		.peak   (l_peak)
	);

	dswer_chan #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.TIME_BITS  (TIME_BITS)
	) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.level  (right_level),
		.now    (now_q),
		.window (win_q),
		.pop    (r_pop),
		.drop   (r_drop),
		.rate   (r_rate),
		.peak   (r_peak)
	);

	assign sts.pop_any  = l_pop | r_pop;
	assign sts.out_free = !valid_q || out_ready;

	// Result register: holds a beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.finish) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			l_rate_q <= l_rate;
			r_rate_q <= r_rate;
			l_peak_q <= l_peak;
			r_peak_q <= r_peak;
			ovf_q    <= l_drop | r_drop;
		end
	end

	assign out_valid  = valid_q;
	assign left_rate  = l_rate_q;
	assign right_rate = r_rate_q;
	assign left_peak  = l_peak_q;
	assign right_peak = r_peak_q;
	assign overflow   = ovf_q;

endmodule

`default_nettype wire

### dv/testbench.sv
// Testbench for the dual sliding-window event rate counter: directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;
	import dswer_pkg::*;

	localparam int DEPTH          = DEF_FIFO_DEPTH;
	localparam int RANDOM_ITEMS   = 950;
	localparam int CFG_SETTLE     = 8;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DIRECTED_ROWS  = 23;
	localparam int EXP_SLOTS      = 16;

	// One result beat as the block reports it
	typedef struct packed {
		logic [RATE_W-1:0] left_rate;
		logic [RATE_W-1:0] right_rate;
		logic [RATE_W-1:0] left_peak;
		logic [RATE_W-1:0] right_peak;
		logic              overflow;
	} rate_beat_t;

	typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_e;

	// Directed row: a sample beat or a window write; typed rows carry their own result
	typedef struct packed {
		row_kind_e         kind;
		logic [TIME_W-1:0] value;
		logic              left;
		logic              right;
		logic              typed;
		rate_beat_t        want;
	} stim_row_t;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// reset state, window 1000
		'{ROW_SAMPLE, 32'd0,        1'b0, 1'b0, 1'b1, {7'd0, 7'd0, 7'd0, 7'd0, 1'b0}},
		'{ROW_SAMPLE, 32'd10,       1'b1, 1'b0, 1'b1, {7'd1, 7'd0, 7'd1, 7'd0, 1'b0}},
		'{ROW_SAMPLE, 32'd20,       1'b1, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, 32'd30,       1'b0, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, 32'd40,       1'b1, 1'b0, 1'b1, {7'd2, 7'd1, 7'd2, 7'd1, 1'b0}},
		// age equal to the window still counts
		'{ROW_SAMPLE, 32'd1010,     1'b0, 1'b0, 1'b1, {7'd2, 7'd1, 7'd2, 7'd1, 1'b0}},
		'{ROW_SAMPLE, 32'd1011,     1'b0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'd1021,     1'b0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'd1041,     1'b0, 1'b0, 1'b1, {7'd0, 7'd0, 7'd2, 7'd1, 1'b0}},
		// zero window: only a stamp equal to now survives
		'{ROW_WINDOW, 32'd0,        1'b0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'd2000,     1'b1, 1'b1, 1'b1, {7'd1, 7'd1, 7'd2, 7'd1, 1'b0}},
		'{ROW_SAMPLE, 32'd2001,     1'b0, 1'b0, 1'b1, {7'd0, 7'd0, 7'd2, 7'd1, 1'b0}},
		// widest window across the timestamp wrap
		'{ROW_WINDOW, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'hFFFFFFF0, 1'b1, 1'b0, 1'b1, {7'd1, 7'd0, 7'd2, 7'd1, 1'b0}},
		'{ROW_SAMPLE, 32'h00000005, 1'b0, 1'b1, 1'b1, {7'd1, 7'd1, 7'd2, 7'd1, 1'b0}},
		'{ROW_SAMPLE, 32'h12345678, 1'b1, 1'b0, 1'b1, {7'd2, 7'd1, 7'd2, 7'd1, 1'b0}},
		// narrowest nonzero window
		'{ROW_WINDOW, 32'd1,        1'b0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h12345679, 1'b0, 1'b0, 1'b1, {7'd1, 7'd0, 7'd2, 7'd1, 1'b0}},
		'{ROW_SAMPLE, 32'h1234567A, 1'b0, 1'b0, 1'b1, {7'd0, 7'd0, 7'd2, 7'd1, 1'b0}},
		// age measured across the wrap
		'{ROW_WINDOW, 32'd16,       1'b0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, {7'd1, 7'd1, 7'd2, 7'd1, 1'b0}},
		'{ROW_SAMPLE, 32'h0000000F, 1'b0, 1'b0, 1'b1, {7'd1, 7'd1, 7'd2, 7'd1, 1'b0}},
		'{ROW_SAMPLE, 32'h00000010, 1'b0, 1'b0, 1'b1, {7'd0, 7'd0, 7'd2, 7'd1, 1'b0}}
	};

	logic clk;
	logic arst_n;

	dswer_sample_if sample_ch ();
	dswer_result_if result_ch ();
	dswer_cfg_if    cfg_ch ();

	dual_sliding_window_event_rate u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: channel 0 is left, channel 1 is right
	logic [TIME_W-1:0] win_ticks;
	logic [TIME_W-1:0] stamp_mem [2][DEPTH];
	int unsigned       chan_fill [2];
	int unsigned       chan_head [2];
	bit                chan_prev [2];
	int unsigned       chan_peak [2];

	// Expected result beats, oldest first, in a small ring
	rate_beat_t exp_buf [EXP_SLOTS];
	int         exp_wr_cnt;
	int         exp_rd_cnt;
	int         error_count;
	int         beat_count;
	int         stall_cycles;
	int         tx_idle_pct;
	int         rx_idle_pct;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			flag_mismatch($sformatf("beat %0d %s: got %0d expected %0d",
				beat_count, name, got, want));
	endtask

	function automatic int exp_level();
		return exp_wr_cnt - exp_rd_cnt;
	endfunction

	function automatic void exp_add(input rate_beat_t b);
		exp_buf[exp_wr_cnt % EXP_SLOTS] = b;
		exp_wr_cnt++;
	endfunction

	function automatic logic [RATE_W-1:0] clip_count(input int unsigned n);
		return (n > RATE_MAX) ? RATE_MAX : RATE_W'(n);
	endfunction

	// Push on a rising level, then expire stamps older than the window; 1 if the press was dropped
	function automatic bit advance_channel(input int ch, input logic [TIME_W-1:0] now,
		input bit level);
		bit dropped;
		dropped = 1'b0;
		if (level && !chan_prev[ch]) begin
			if (chan_fill[ch] >= DEPTH) begin
				dropped = 1'b1;
			end else begin
				stamp_mem[ch][(chan_head[ch] + chan_fill[ch]) % DEPTH] = now;
				chan_fill[ch]++;
			end
		end
		chan_prev[ch] = level;
		while (chan_fill[ch] > 0 &&
			TIME_W'(now - stamp_mem[ch][chan_head[ch]]) > win_ticks) begin
			chan_head[ch] = (chan_head[ch] + 1) % DEPTH;
			chan_fill[ch]--;
		end
		if (chan_fill[ch] > chan_peak[ch])
			chan_peak[ch] = chan_fill[ch];
		return dropped;
	endfunction

	function automatic rate_beat_t predict_rates(input logic [TIME_W-1:0] now, input bit l,
		input bit r);
		rate_beat_t beat;
		bit         dropped;
		dropped = advance_channel(0, now, l);
		dropped |= advance_channel(1, now, r);
		beat.left_rate  = clip_count(chan_fill[0]);
		beat.right_rate = clip_count(chan_fill[1]);
		beat.left_peak  = clip_count(chan_peak[0]);
		beat.right_peak = clip_count(chan_peak[1]);
		beat.overflow   = dropped;
		return beat;
	endfunction

	// Offer one sample beat, with a random gap first, and hold it until taken
	task automatic drive_sample(input logic [TIME_W-1:0] now, input bit l, input bit r);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		sample_ch.valid         <= 1'b1;
		sample_ch.time_now      <= now;
		sample_ch.left_pressed  <= l;
		sample_ch.right_pressed <= r;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// Window writes only once every result beat is back
	task automatic write_window(input logic [WIN_W-1:0] w);
		sample_ch.valid <= 1'b0;
		while (exp_level() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.window_ticks <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		win_ticks = w;
	endtask

	// Result checker and receiver stalls
	always @(posedge clk) begin
		rate_beat_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (exp_level() == 0) begin
				flag_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
			end else begin
				want = exp_buf[exp_rd_cnt % EXP_SLOTS];
				exp_rd_cnt++;
				compare_field("left_rate", result_ch.left_rate, want.left_rate);
				compare_field("right_rate", result_ch.right_rate, want.right_rate);
				compare_field("left_peak", result_ch.left_peak, want.left_peak);
				compare_field("right_peak", result_ch.right_peak, want.right_peak);
				compare_field("overflow", result_ch.overflow, want.overflow);
			end
			beat_count++;
		end
		result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				stall_cycles, exp_level());
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [TIME_W-1:0] cur_time;
		logic [TIME_W-1:0] max_step;
		logic [WIN_W-1:0]  seg_win;
		int                seg_kind;
		int                seg_len;
		int                phase_items;
		bit                first_seg;
		bit                lvl_l;
		bit                lvl_r;
		rate_beat_t        pred;

		arst_n                  = 1'b0;
		sample_ch.valid         = 1'b0;
		sample_ch.time_now      = '0;
		sample_ch.left_pressed  = 1'b0;
		sample_ch.right_pressed = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.window_ticks     = '0;
		result_ch.ready         = 1'b0;
		exp_wr_cnt              = 0;
		exp_rd_cnt              = 0;
		error_count             = 0;
		beat_count              = 0;
		stall_cycles            = 0;
		tx_idle_pct             = 13;
		rx_idle_pct             = 84;

		win_ticks = WINDOW_RESET;
		for (int c = 0; c < 2; c++) begin
			chan_fill[c] = 0;
			chan_head[c] = 0;
			chan_prev[c] = 1'b0;
			chan_peak[c] = 0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_WINDOW) begin
				write_window(DIRECTED[i].value);
			end else begin
				drive_sample(DIRECTED[i].value, DIRECTED[i].left, DIRECTED[i].right);
				pred = predict_rates(DIRECTED[i].value, DIRECTED[i].left, DIRECTED[i].right);
				exp_add(DIRECTED[i].typed ? DIRECTED[i].want : pred);
			end
		end

		// Random segments, each under its own window setting
		cur_time = 32'h0000_1000;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 13;
					rx_idle_pct = 84;
				end
				1: begin
					tx_idle_pct = 84;
					rx_idle_pct = 13;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			phase_items = 0;
			first_seg   = 1'b1;
			while (phase_items < RANDOM_ITEMS / 3) begin
				// last phase opens by filling both FIFOs past capacity
				seg_kind = (phase == 2 && first_seg) ? 9 : $urandom_range(0, 9);
				first_seg = 1'b0;
				seg_len   = $urandom_range(20, 60);
				case (seg_kind)
					0, 1: begin
						seg_win  = $urandom_range(0, 8);
						max_step = 3;
					end
					2, 3: begin
						seg_win  = $urandom_range(50, 500);
						max_step = 60;
					end
					4: begin
						seg_win  = '1;
						max_step = '1;
					end
					5: begin
						seg_win  = $urandom;
						max_step = '1;
					end
					9: begin
						seg_win  = '1;
						max_step = 4;
						seg_len  = 2 * DEPTH + 12;
					end
					default: begin
						seg_win  = $urandom_range(1000, 5000);
						max_step = 100;
					end
				endcase
				write_window(seg_win);
				for (int k = 0; k < seg_len; k++) begin
					if (seg_kind == 5)
						cur_time = $urandom;
					else if (max_step == '1)
						cur_time = cur_time + $urandom;
					else
						cur_time = cur_time + $urandom_range(0, max_step);
					if (seg_kind == 9) begin
						lvl_l = k[0];
						lvl_r = !k[0];
					end else begin
						lvl_l = $urandom_range(0, 1);
						lvl_r = $urandom_range(0, 1);
					end
					drive_sample(cur_time, lvl_l, lvl_r);
					exp_add(predict_rates(cur_time, lvl_l, lvl_r));
				end
				phase_items += seg_len;
			end
		end

		// Drain, then give a late or extra beat time to show up
		sample_ch.valid <= 1'b0;
		while (exp_level() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/dswer_pkg.sv
rtl/dswer_if.sv
rtl/dswer_ctrl.sv
rtl/dswer_chan.sv
rtl/dswer_dp.sv
rtl/dual_sliding_window_event_rate.sv
dv/testbench.sv
